// ===== rtl/core/rfg_pkg.sv =====
// ---------------------------------------------------------------------------
// rfg_pkg
// shared types, codes and helpers of the rectangle fill and gradient engine
// ---------------------------------------------------------------------------
package rfg_pkg;

   localparam int COORD_W  = 7;   // column or row on the surface
   localparam int CHAN_W   = 8;   // one colour channel
   localparam int NUM_CHAN = 4;
   localparam int REM_W    = 6;   // span minus one, at most 63
   localparam int LIMIT_W  = 13;  // holds the largest MAX_WIDTH or MAX_HEIGHT
   localparam int CSR_W    = 7;

   localparam logic [CSR_W-1:0] SURFACE_RESET = 7'd64;

   localparam logic REG_SURFACE_WIDTH  = 1'b0;
   localparam logic REG_SURFACE_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      OP_FILL     = 2'd0,
      OP_GRADIENT = 2'd1,
      OP_WRITE    = 2'd2,
      OP_READ     = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_WALK,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic              start;
      logic [CHAN_W-1:0] dividend;
      logic [REM_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [CHAN_W-1:0] quotient;
      logic [REM_W-1:0]  remainder;
   } div_rsp_type;

   // argb to stored layout: red 7:0, green 15:8, blue 23:16, alpha 31:24
   function automatic logic [31:0] argb_to_store(input logic [31:0] c);
      return {c[31:24], c[7:0], c[15:8], c[23:16]};
   endfunction

endpackage

// ===== rtl/core/rect_fill_gradient_engine_top.sv =====
// ---------------------------------------------------------------------------
// rect_fill_gradient_engine_top
// rectangle fill, linear gradient, pixel write and pixel read over a store
// of 32-bit rgba words
// ---------------------------------------------------------------------------
//
//   channel   ports                         handshake
//   -------   ---------------------------   -------------------------------
//   request   start, busy, req_*            taken when start=1 and busy=0
//   result    rsp_valid, rsp_*              one-cycle strobe, never stalled
//   config    csr_write_en, csr_index,      written on any edge with
//             csr_wdata                     csr_write_en=1, no wait
//
// write pixel and read pixel go from accept through decode to the result strobe
// fill: the walker writes one pixel per cycle through the single store write
//   port; out-of-surface pixels are still walked, with the write held off
// gradient with a span of 2 or more first runs a divide phase: one shared
//   restoring divider works out |to-from| / (span-1) for each channel in turn,
//   an 8-bit quotient and a remainder per channel
// busy stays high from accept through the result cycle; start is ignored
// synchronous reset returns the sequencer to idle and the surface size to
//   64 by 64; store contents are left as they are (read only after written)
// ---------------------------------------------------------------------------
module rect_fill_gradient_engine_top #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_rect_x,
   input  logic [5:0]  req_rect_y,
   input  logic [6:0]  req_rect_w,
   input  logic [6:0]  req_rect_h,
   input  logic [31:0] req_color_from,
   input  logic [31:0] req_color_to,
   input  logic        req_vertical,
   // result
   output logic        rsp_valid,
   output logic [31:0] rsp_pixel_data,
   output logic        rsp_clipped,
   // configuration
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW     = rfg_pkg::CHAN_W;
   localparam int NCH    = rfg_pkg::NUM_CHAN;

   localparam logic [rfg_pkg::LIMIT_W-1:0] MAX_W_LIM = rfg_pkg::LIMIT_W'(MAX_WIDTH);
   localparam logic [rfg_pkg::LIMIT_W-1:0] MAX_H_LIM = rfg_pkg::LIMIT_W'(MAX_HEIGHT);
   localparam logic [ADDR_W-1:0]           ROW_PITCH = ADDR_W'(MAX_WIDTH);

   // sequencer
   rfg_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [rfg_pkg::CSR_W-1:0] surf_w_ff, surf_h_ff;

   // latched command
   rfg_pkg::opcode_type op_ff;
   logic [5:0]          rx_ff, ry_ff;
   logic [6:0]          rw_ff, rh_ff;
   logic [31:0]         cfrom_ff, cto_ff;
   logic                vert_ff;

   // walker and ramp state
   logic [5:0]          i_ff, i_in;
   logic [5:0]          j_ff, j_in;
   logic                clip_ff, clip_in;
   logic [1:0]          ch_ff, ch_in;
   logic                ramp_on_ff, ramp_on_in;
   logic [rfg_pkg::REM_W-1:0] dvs_ff, dvs_in;
   logic [NCH-1:0]      neg_ff, neg_in;
   logic [CW-1:0]       q0_ff [NCH];
   logic [CW-1:0]       q0_in [NCH];
   logic [rfg_pkg::REM_W-1:0] r0_ff [NCH];
   logic [rfg_pkg::REM_W-1:0] r0_in [NCH];
   logic [CW-1:0]       qacc_ff [NCH];
   logic [CW-1:0]       qacc_in [NCH];
   logic [rfg_pkg::REM_W-1:0] racc_ff [NCH];
   logic [rfg_pkg::REM_W-1:0] racc_in [NCH];

   // combinational datapath
   logic                accept;
   logic [31:0]         from_s, to_s;
   logic [6:0]          span;
   logic                empty;
   logic [rfg_pkg::COORD_W-1:0] col, row;
   logic                in_bounds;
   logic [ADDR_W-1:0]   addr;
   logic                row_end, last_pixel;
   logic                acc_step, acc_clear;
   logic [31:0]         ramp_word;
   logic [CW-1:0]       f_sel, t_sel;

   // store port
   logic                ram_we, ram_re;
   logic [31:0]         ram_wdata, ram_rdata;

   rfg_pkg::div_req_type div_req;
   rfg_pkg::div_rsp_type div_rsp;

   assign accept = start && (state_ff == rfg_pkg::ST_IDLE);
   assign busy   = (state_ff != rfg_pkg::ST_IDLE);

   assign from_s = rfg_pkg::argb_to_store(cfrom_ff);
   assign to_s   = rfg_pkg::argb_to_store(cto_ff);
   assign span   = vert_ff ? rh_ff : rw_ff;
   assign empty  = (rw_ff == 7'd0) || (rh_ff == 7'd0);

   // pixel position and clipping against register and store limits
   assign col = 7'(rx_ff) + 7'(i_ff);
   assign row = 7'(ry_ff) + 7'(j_ff);
   assign in_bounds = (col < surf_w_ff) && (rfg_pkg::LIMIT_W'(col) < MAX_W_LIM) &&
                      (row < surf_h_ff) && (rfg_pkg::LIMIT_W'(row) < MAX_H_LIM);
   assign addr = ADDR_W'(row) * ROW_PITCH + ADDR_W'(col);

   assign row_end    = ({1'b0, i_ff} == rw_ff - 7'd1);
   assign last_pixel = row_end && ({1'b0, j_ff} == rh_ff - 7'd1);

   // position along the ramp: advances per column across, per row down
   assign acc_clear = state_ff == rfg_pkg::ST_WALK && !vert_ff && row_end;
   assign acc_step  = state_ff == rfg_pkg::ST_WALK && (vert_ff ? row_end : !row_end);

   // divider feed: magnitude of to-from for the current channel
   assign f_sel = from_s[ch_ff*CW +: CW];
   assign t_sel = to_s[ch_ff*CW +: CW];
   assign div_req.dividend = neg_ff[ch_ff] ? f_sel - t_sel : t_sel - f_sel;
   assign div_req.divisor  = dvs_ff;
   assign div_req.start    = (state_ff == rfg_pkg::ST_DIVIDE) && !div_rsp.busy &&
                             !div_rsp.done;

   rfg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ramp word and accumulator update, one lane per channel
   always_comb begin
      logic [CW-1:0]             fb;
      logic [rfg_pkg::REM_W:0]   rsum;
      logic                      carry;
      ramp_word = '0;
      for (int k = 0; k < NCH; k++) begin
         fb = from_s[k*CW +: CW];
         ramp_word[k*CW +: CW] = neg_ff[k] ? fb - qacc_ff[k] : fb + qacc_ff[k];
         rsum  = {1'b0, racc_ff[k]} + {1'b0, r0_ff[k]};
         carry = ramp_on_ff && (rsum >= {1'b0, dvs_ff});
         qacc_in[k] = qacc_ff[k];
         racc_in[k] = racc_ff[k];
         if (accept || acc_clear) begin
            qacc_in[k] = '0;
            racc_in[k] = '0;
         end else if (acc_step) begin
            qacc_in[k] = qacc_ff[k] + q0_ff[k] + CW'(carry);
            racc_in[k] = carry ? rfg_pkg::REM_W'(rsum - {1'b0, dvs_ff})
                               : rfg_pkg::REM_W'(rsum);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rfg_pkg::ST_IDLE: begin
            if (start) state_in = rfg_pkg::ST_DECODE;
         end
         rfg_pkg::ST_DECODE: begin
            priority if (op_ff == rfg_pkg::OP_WRITE || op_ff == rfg_pkg::OP_READ || empty)
               state_in = rfg_pkg::ST_RESPOND;
            else if (op_ff == rfg_pkg::OP_GRADIENT && span >= 7'd2)
               state_in = rfg_pkg::ST_DIVIDE;
            else
               state_in = rfg_pkg::ST_WALK;
         end
         rfg_pkg::ST_DIVIDE: begin
            if (div_rsp.done && ch_ff == 2'd3) state_in = rfg_pkg::ST_WALK;
         end
         rfg_pkg::ST_WALK: begin
            if (last_pixel) state_in = rfg_pkg::ST_RESPOND;
         end
         rfg_pkg::ST_RESPOND: begin
            state_in = rfg_pkg::ST_IDLE;
         end
         default: state_in = rfg_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      i_in       = i_ff;
      j_in       = j_ff;
      clip_in    = clip_ff;
      ch_in      = ch_ff;
      ramp_on_in = ramp_on_ff;
      dvs_in     = dvs_ff;
      neg_in     = neg_ff;
      q0_in      = q0_ff;
      r0_in      = r0_ff;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_wdata  = ramp_word;
      unique case (state_ff)
         rfg_pkg::ST_IDLE: begin
            if (start) begin
               i_in    = '0;
               j_in    = '0;
               clip_in = 1'b0;
            end
         end
         rfg_pkg::ST_DECODE: begin
            ch_in      = '0;
            ramp_on_in = (op_ff == rfg_pkg::OP_GRADIENT) && (span >= 7'd2);
            dvs_in     = rfg_pkg::REM_W'(span - 7'd1);
            for (int k = 0; k < NCH; k++) begin
               neg_in[k] = to_s[k*CW +: CW] < from_s[k*CW +: CW];
               q0_in[k]  = '0;
               r0_in[k]  = '0;
            end
            if (op_ff == rfg_pkg::OP_WRITE || op_ff == rfg_pkg::OP_READ) begin
               clip_in = !in_bounds;
            end
            ram_we    = (op_ff == rfg_pkg::OP_WRITE) && in_bounds;
            ram_re    = (op_ff == rfg_pkg::OP_READ) && in_bounds;
            ram_wdata = cfrom_ff;
         end
         rfg_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               q0_in[ch_ff] = div_rsp.quotient;
               r0_in[ch_ff] = div_rsp.remainder;
               ch_in        = ch_ff + 2'd1;
            end
         end
         rfg_pkg::ST_WALK: begin
            ram_we  = in_bounds;
            clip_in = clip_ff || !in_bounds;
            if (row_end) begin
               i_in = '0;
               j_in = j_ff + 6'd1;
            end else begin
               i_in = i_ff + 6'd1;
            end
         end
         rfg_pkg::ST_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rfg_pkg::ST_IDLE;
         surf_w_ff <= rfg_pkg::SURFACE_RESET;
         surf_h_ff <= rfg_pkg::SURFACE_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            unique case (csr_index)
               rfg_pkg::REG_SURFACE_WIDTH:  surf_w_ff <= csr_wdata;
               rfg_pkg::REG_SURFACE_HEIGHT: surf_h_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      // command latch, payload only
      if (accept) begin
         op_ff    <= rfg_pkg::opcode_type'(req_opcode);
         rx_ff    <= req_rect_x;
         ry_ff    <= req_rect_y;
         rw_ff    <= req_rect_w;
         rh_ff    <= req_rect_h;
         cfrom_ff <= req_color_from;
         cto_ff   <= req_color_to;
         vert_ff  <= req_vertical;
      end
      i_ff       <= i_in;
      j_ff       <= j_in;
      clip_ff    <= clip_in;
      ch_ff      <= ch_in;
      ramp_on_ff <= ramp_on_in;
      dvs_ff     <= dvs_in;
      neg_ff     <= neg_in;
      q0_ff      <= q0_in;
      r0_ff      <= r0_in;
      qacc_ff    <= qacc_in;
      racc_ff    <= racc_in;
   end

   // pixel store
   rfg_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   // result: read data only for an in-surface read, zero otherwise
   assign rsp_valid      = (state_ff == rfg_pkg::ST_RESPOND);
   assign rsp_clipped    = clip_ff;
   assign rsp_pixel_data = (op_ff == rfg_pkg::OP_READ && !clip_ff) ? ram_rdata : 32'd0;

`ifndef ASSERT_OFF
   // the result cycle always hands control back to idle
   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("engine still busy after result strobe");

   // an accepted item makes the engine busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // only a read may return nonzero pixel data
   a_data_read_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pixel_data != 32'd0) |-> (op_ff == rfg_pkg::OP_READ))
      else $error("pixel data on a non-read result");

   // store writes happen only while decoding a pixel write or walking a rectangle
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == rfg_pkg::ST_WALK || state_ff == rfg_pkg::ST_DECODE))
      else $error("store written outside decode or walk");
`endif

endmodule

// ===== rtl/core/rfg_ram.sv =====
// ---------------------------------------------------------------------------
// rfg_ram
// generic single-port-write, single-port-read ram with registered read data
// ---------------------------------------------------------------------------
module rfg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rfg_div.sv =====
// ---------------------------------------------------------------------------
// rfg_div
// restoring divider, one quotient bit per cycle, shared by the four channels
// ---------------------------------------------------------------------------
module rfg_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rfg_pkg::div_req_type req,
   output rfg_pkg::div_rsp_type rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [2:0]                   count_ff, count_in;
   logic [rfg_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [rfg_pkg::CHAN_W-1:0]   quo_ff, quo_in;
   logic [rfg_pkg::REM_W-1:0]    divisor_ff, divisor_in;
   logic [rfg_pkg::REM_W:0]      shifted;
   logic                         fits;

   // partial remainder with the next dividend bit shifted in
   assign shifted = {rem_ff, quo_ff[rfg_pkg::CHAN_W-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (req.start && !busy_ff) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? rfg_pkg::REM_W'(shifted - {1'b0, divisor_ff})
                         : rfg_pkg::REM_W'(shifted);
         quo_in   = {quo_ff[rfg_pkg::CHAN_W-2:0], fits};
         count_in = count_ff + 3'd1;
         if (count_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== test/tb_rect_fill_gradient_engine_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rect_fill_gradient_engine_top
// self-checking bench for the rectangle fill and gradient engine: a shadow
// surface predicts every reply, commands come from a queue under random
// sender gaps, replies are checked in order against the shadow
// ---------------------------------------------------------------------------
module tb_rect_fill_gradient_engine_top;
   import rfg_pkg::*;

   localparam int SURF_MAX      = 64;     // MAX_WIDTH and MAX_HEIGHT of the dut
   localparam int STALL_LIMIT   = 20000;  // watchdog limit, above the length of a full 64x64 gradient
   localparam int SETTLE_CYCLES = 8;      // settling margin after the engine goes idle

   // one command item as it goes onto the request ports
   typedef struct {
      opcode_type  opcode;
      logic [5:0]  rect_x;
      logic [5:0]  rect_y;
      logic [6:0]  rect_w;
      logic [6:0]  rect_h;
      logic [31:0] color_from;
      logic [31:0] color_to;
      logic        vertical;
   } command_type;

   // one reply item as it comes off the result ports
   typedef struct {
      logic [31:0] pixel_data;
      logic        clipped;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_FILL;
   logic [5:0]  req_rect_x = '0;
   logic [5:0]  req_rect_y = '0;
   logic [6:0]  req_rect_w = '0;
   logic [6:0]  req_rect_h = '0;
   logic [31:0] req_color_from = '0;
   logic [31:0] req_color_to = '0;
   logic        req_vertical = 1'b0;
   logic        rsp_valid;
   logic [31:0] rsp_pixel_data;
   logic        rsp_clipped;
   logic        csr_write_en = 1'b0;
   logic        csr_index = REG_SURFACE_WIDTH;
   logic [6:0]  csr_wdata = '0;

   // shadow of the dut: pixel store and surface size registers
   logic [31:0] canvas [SURF_MAX*SURF_MAX];
   logic [6:0]  canvas_w = SURFACE_RESET;
   logic [6:0]  canvas_h = SURFACE_RESET;

   command_type pending_cmds[$];     // items waiting for the driver
   reply_type   awaited_replies[$];  // predicted replies, oldest first
   command_type held_cmd;            // item currently on the request ports
   int          sender_idle_pct = 36;
   int          error_count = 0;
   int          stall_cycles = 0;
   logic [5:0]  last_x = '0;
   logic [5:0]  last_y = '0;

   rect_fill_gradient_engine_top #(
      .MAX_WIDTH  (SURF_MAX),
      .MAX_HEIGHT (SURF_MAX)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_rect_x     (req_rect_x),
      .req_rect_y     (req_rect_y),
      .req_rect_w     (req_rect_w),
      .req_rect_h     (req_rect_h),
      .req_color_from (req_color_from),
      .req_color_to   (req_color_to),
      .req_vertical   (req_vertical),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_data (rsp_pixel_data),
      .rsp_clipped    (rsp_clipped),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // --------------------------------------------------------------------
   // prediction
   // --------------------------------------------------------------------

   // register value clamped to the store size
   function automatic int visible(input logic [6:0] reg_value);
      return (int'(reg_value) < SURF_MAX) ? int'(reg_value) : SURF_MAX;
   endfunction

   // argb in, stored layout out: red low byte, then green, blue, alpha
   function automatic logic [31:0] to_store_layout(input logic [31:0] argb);
      logic [7:0] alpha, red, green, blue;
      alpha = argb[31:24];
      red   = argb[23:16];
      green = argb[15:8];
      blue  = argb[7:0];
      return {alpha, blue, green, red};
   endfunction

   // per channel: from + (to - from) * pos / (span - 1), truncated toward zero
   function automatic logic [31:0] ramp_pixel(input logic [31:0] from_s,
                                              input logic [31:0] to_s,
                                              input int pos, input int span);
      logic [31:0] word;
      int          k, f, t, v;
      word = '0;
      for (k = 0; k < NUM_CHAN; k++) begin
         f = int'(from_s[8*k +: 8]);
         t = int'(to_s[8*k +: 8]);
         v = f;
         // a span of one keeps the from colour
         if (span > 1) v = f + ((t - f) * pos) / (span - 1);
         word[8*k +: 8] = v[7:0];
      end
      return word;
   endfunction

   // store one pixel if it lies on the surface; 1 means clipped
   function automatic logic plot(input int col, input int row, input logic [31:0] word);
      if (col >= visible(canvas_w) || row >= visible(canvas_h)) return 1'b1;
      canvas[row*SURF_MAX + col] = word;
      return 1'b0;
   endfunction

   // apply one command to the shadow surface and return its reply
   function automatic reply_type render(input command_type c);
      reply_type   r;
      logic [31:0] from_s, to_s, word;
      int          i, j, span;
      r.pixel_data = '0;
      r.clipped    = 1'b0;
      from_s = to_store_layout(c.color_from);
      to_s   = to_store_layout(c.color_to);
      span   = c.vertical ? int'(c.rect_h) : int'(c.rect_w);
      case (c.opcode)
         OP_FILL, OP_GRADIENT: begin
            // an empty rectangle runs no loop and leaves clipped low
            for (j = 0; j < int'(c.rect_h); j++)
               for (i = 0; i < int'(c.rect_w); i++) begin
                  if (c.opcode == OP_FILL) word = from_s;
                  else word = ramp_pixel(from_s, to_s, c.vertical ? j : i, span);
                  if (plot(int'(c.rect_x) + i, int'(c.rect_y) + j, word)) r.clipped = 1'b1;
               end
         end
         OP_WRITE: begin
            // streamed source word is already in stored layout
            r.clipped = plot(int'(c.rect_x), int'(c.rect_y), c.color_from);
         end
         default: begin
            if (int'(c.rect_x) >= visible(canvas_w) || int'(c.rect_y) >= visible(canvas_h))
               r.clipped = 1'b1;
            else
               r.pixel_data = canvas[int'(c.rect_y)*SURF_MAX + int'(c.rect_x)];
         end
      endcase
      return r;
   endfunction

   // --------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------

   function automatic command_type make_cmd(input opcode_type op,
                                            input int x, input int y,
                                            input int w, input int h,
                                            input logic [31:0] from_c,
                                            input logic [31:0] to_c,
                                            input logic vert);
      command_type c;
      c.opcode     = op;
      c.rect_x     = x[5:0];
      c.rect_y     = y[5:0];
      c.rect_w     = w[6:0];
      c.rect_h     = h[6:0];
      c.color_from = from_c;
      c.color_to   = to_c;
      c.vertical   = vert;
      return c;
   endfunction

   // random command, biased onto the visible surface and toward reading
   // back what was just drawn; rare large rectangles keep the run short
   function automatic command_type random_command();
      command_type c;
      int          pick, vis_w, vis_h;
      vis_w = visible(canvas_w);
      vis_h = visible(canvas_h);
      pick  = $urandom_range(0, 99);
      if (pick < 20)      c.opcode = OP_FILL;
      else if (pick < 50) c.opcode = OP_GRADIENT;
      else if (pick < 70) c.opcode = OP_WRITE;
      else                c.opcode = OP_READ;
      c.rect_x = 6'($urandom_range(0, 63));
      c.rect_y = 6'($urandom_range(0, 63));
      if (vis_w > 0 && vis_h > 0 && $urandom_range(0, 3) != 0) begin
         c.rect_x = 6'($urandom_range(0, vis_w - 1));
         c.rect_y = 6'($urandom_range(0, vis_h - 1));
      end
      if (c.opcode == OP_READ && $urandom_range(0, 1) == 1) begin
         c.rect_x = last_x;
         c.rect_y = last_y;
      end
      if ($urandom_range(0, 19) == 0) begin
         c.rect_w = 7'($urandom_range(0, 64));
         c.rect_h = 7'($urandom_range(0, 64));
      end else begin
         c.rect_w = 7'($urandom_range(0, 6));
         c.rect_h = 7'($urandom_range(0, 6));
      end
      c.color_from = $urandom();
      c.color_to   = $urandom();
      c.vertical   = 1'($urandom_range(0, 1));
      if (c.opcode != OP_READ) begin
         last_x = c.rect_x;
         last_y = c.rect_y;
      end
      return c;
   endfunction

   task automatic queue_random(input int count);
      int n;
      for (n = 0; n < count; n++) pending_cmds.push_back(random_command());
   endtask

   // sampled on falling edges so no queue or port update races the check
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || awaited_replies.size() != 0 || start || busy);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register write; only called while the engine is idle
   task automatic write_surface(input logic idx, input logic [6:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      if (idx == REG_SURFACE_WIDTH) canvas_w = value;
      else canvas_h = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // --------------------------------------------------------------------
   // driver: presents queued items, predicts each one as it is accepted
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         // accepted at this edge: start high while busy low
         if (start && !busy) awaited_replies.push_back(render(held_cmd));
         // free to present the next item unless one is still held
         if (!start || !busy) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               held_cmd       = pending_cmds.pop_front();
               req_opcode     <= held_cmd.opcode;
               req_rect_x     <= held_cmd.rect_x;
               req_rect_y     <= held_cmd.rect_y;
               req_rect_w     <= held_cmd.rect_w;
               req_rect_h     <= held_cmd.rect_h;
               req_color_from <= held_cmd.color_from;
               req_color_to   <= held_cmd.color_to;
               req_vertical   <= held_cmd.vertical;
               start          <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // monitor: checks each reply strobe, runs the stall watchdog
   // --------------------------------------------------------------------
   always @(posedge clock) begin : reply_check
      reply_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               flag_mismatch("reply with none awaited", rsp_pixel_data, '0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_pixel_data !== want.pixel_data)
                  flag_mismatch("pixel_data", rsp_pixel_data, want.pixel_data);
               if (rsp_clipped !== want.clipped)
                  flag_mismatch("clipped", {31'd0, rsp_clipped}, {31'd0, want.clipped});
            end
         end
         // any accepted item or reply counts as progress
         if (rsp_valid || (start && !busy)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles at %0t", stall_cycles, $time);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------
   // test sequence
   // --------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset surface of 64 by 64
      sender_idle_pct = 36;
      // full-surface fill first: every later read hits a written word
      pending_cmds.push_back(make_cmd(OP_FILL, 0, 0, 64, 64, 32'hA5C3_5A3C, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, '0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_READ, 63, 63, 0, 0, '0, '0, 1'b0));
      // empty rectangles write nothing and do not clip
      pending_cmds.push_back(make_cmd(OP_FILL, 3, 3, 0, 5, 32'hFFFF_FFFF, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_FILL, 3, 3, 5, 0, 32'hFFFF_FFFF, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_GRADIENT, 3, 3, 0, 9, '0, 32'hFFFF_FFFF, 1'b1));
      // fills hanging off the right and bottom edges
      pending_cmds.push_back(make_cmd(OP_FILL, 60, 60, 8, 8, 32'h5A3C_A5C3, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_FILL, 63, 63, 64, 64, 32'hFFFF_FFFF, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_READ, 63, 63, 0, 0, '0, '0, 1'b0));
      // full-width rising ramp and full-height ramp, alpha and green falling, red and blue rising
      pending_cmds.push_back(make_cmd(OP_GRADIENT, 0, 10, 64, 1, 32'h0000_0000,
                                      32'hFFFF_FFFF, 1'b0));
      pending_cmds.push_back(make_cmd(OP_READ, 37, 10, 0, 0, '0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_GRADIENT, 5, 0, 1, 64, 32'hFF00_FF00,
                                      32'h00FF_00FF, 1'b1));
      pending_cmds.push_back(make_cmd(OP_READ, 5, 41, 0, 0, '0, '0, 1'b0));
      // span of one in both directions
      pending_cmds.push_back(make_cmd(OP_GRADIENT, 20, 20, 1, 3, 32'h1234_5678,
                                      32'h8765_4321, 1'b0));
      pending_cmds.push_back(make_cmd(OP_GRADIENT, 20, 30, 3, 1, 32'h1234_5678,
                                      32'h8765_4321, 1'b1));
      pending_cmds.push_back(make_cmd(OP_READ, 21, 30, 0, 0, '0, '0, 1'b0));
      // gradient partly off the right edge
      pending_cmds.push_back(make_cmd(OP_GRADIENT, 62, 40, 4, 2, 32'h80FF_0080,
                                      32'h7F00_FF7F, 1'b0));
      // pixel write and read back at the corners
      pending_cmds.push_back(make_cmd(OP_WRITE, 63, 63, 0, 0, 32'hDEAD_BEEF, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_READ, 63, 63, 0, 0, '0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_WRITE, 0, 0, 64, 64, 32'h0000_0000,
                                      32'hFFFF_FFFF, 1'b1));
      pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, '0, '0, 1'b0));
      wait_idle();

      // zero width register: every pixel clips, reads give zero
      write_surface(REG_SURFACE_WIDTH, 7'd0);
      write_surface(REG_SURFACE_HEIGHT, 7'd37);
      pending_cmds.push_back(make_cmd(OP_FILL, 0, 0, 2, 2, 32'h1111_2222, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_WRITE, 0, 0, 0, 0, 32'h3333_4444, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, '0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_GRADIENT, 1, 1, 3, 3, '0, 32'hFFFF_FFFF, 1'b1));
      wait_idle();

      // random phases, sender gaps 36 then 56 then none
      write_surface(REG_SURFACE_WIDTH, 7'd64);
      write_surface(REG_SURFACE_HEIGHT, 7'd64);
      queue_random(20);
      // drain fully mid-phase before carrying on
      wait_idle();
      queue_random(15);
      wait_idle();

      sender_idle_pct = 56;
      write_surface(REG_SURFACE_WIDTH, 7'd1);
      write_surface(REG_SURFACE_HEIGHT, 7'd1);
      queue_random(15);
      wait_idle();

      write_surface(REG_SURFACE_WIDTH, 7'd23);
      write_surface(REG_SURFACE_HEIGHT, 7'd41);
      queue_random(30);
      wait_idle();

      sender_idle_pct = 0;
      write_surface(REG_SURFACE_WIDTH, 7'd64);
      write_surface(REG_SURFACE_HEIGHT, 7'd64);
      queue_random(35);
      wait_idle();

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
